/* rtl/core/fsfp_pkg.sv */
// ----------------------------------------------------------------------------
// fsfp_pkg
// Shared types and constants for the flow sensor frame parser.
// ----------------------------------------------------------------------------
package fsfp_pkg;

    // Frame length must be strictly below this value.
    localparam int MAX_LEN = 50;

    // Configuration reset values.
    localparam logic [7:0] HEADER_RST     = 8'hAA;
    localparam logic [7:0] FUNC_LIMIT_RST = 8'hF2;
    localparam logic [7:0] ACC_FUNC_RST   = 8'hF1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HEADER    = 2'd0,
        CFG_FUNC_LIM  = 2'd1,
        CFG_ACC_FUNC  = 2'd2
    } t_cfg_idx;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_FUNC = 3'd2,
        PH_LEN  = 3'd3,
        PH_PAY  = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    // Operation passed from the parser front to the store back.
    typedef struct packed {
        logic       is_check;  // checksum byte: closes the frame
        logic       hit;       // checksum and function matched
        logic       wr_en;     // byte lands in the payload store
        logic [2:0] idx;       // store position
        logic [7:0] data;
    } t_op;

    // Queue depth between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

/* rtl/core/fsfp_front.sv */
// ----------------------------------------------------------------------------
// fsfp_front
// Byte classifier: header hunt, function/length checks, running sum.
// ----------------------------------------------------------------------------
module fsfp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_push,
    output fsfp_pkg::t_op    o_op
);

    logic [7:0]       r_header;
    logic [7:0]       r_func_lim;
    logic [7:0]       r_acc_func;

    fsfp_pkg::t_phase r_phase, n_phase;
    logic [5:0]       r_rem, n_rem;
    logic [5:0]       r_idx, n_idx;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_func, n_func;

    logic             w_idx_lo;

    assign w_idx_lo = (r_idx[5:3] == 3'd0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= fsfp_pkg::HEADER_RST;
            r_func_lim <= fsfp_pkg::FUNC_LIMIT_RST;
            r_acc_func <= fsfp_pkg::ACC_FUNC_RST;
        end else if (i_cfg_we) begin
            case (fsfp_pkg::t_cfg_idx'(i_cfg_idx))
                fsfp_pkg::CFG_HEADER:   r_header   <= i_cfg_data;
                fsfp_pkg::CFG_FUNC_LIM: r_func_lim <= i_cfg_data;
                fsfp_pkg::CFG_ACC_FUNC: r_acc_func <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next phase.
    always_comb begin
        n_phase = fsfp_pkg::PH_HDR1;
        case (r_phase)
            fsfp_pkg::PH_HDR1:
                n_phase = (i_rx_byte == r_header) ? fsfp_pkg::PH_HDR2 : fsfp_pkg::PH_HDR1;
            fsfp_pkg::PH_HDR2:
                n_phase = (i_rx_byte == r_header) ? fsfp_pkg::PH_FUNC : fsfp_pkg::PH_HDR1;
            fsfp_pkg::PH_FUNC:
                n_phase = (i_rx_byte < r_func_lim) ? fsfp_pkg::PH_LEN : fsfp_pkg::PH_HDR1;
            fsfp_pkg::PH_LEN:
                n_phase = (i_rx_byte < 8'(fsfp_pkg::MAX_LEN)) ? fsfp_pkg::PH_PAY
                                                              : fsfp_pkg::PH_HDR1;
            fsfp_pkg::PH_PAY: begin
                if (r_rem == 6'd0)
                    n_phase = fsfp_pkg::PH_HDR1;
                else if (r_rem == 6'd1)
                    n_phase = fsfp_pkg::PH_SUM;
                else
                    n_phase = fsfp_pkg::PH_PAY;
            end
            default: n_phase = fsfp_pkg::PH_HDR1;
        endcase
    end

    // Datapath and queue push.
    always_comb begin
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_func      = r_func;
        o_push      = 1'b0;
        o_op        = '0;
        o_op.idx    = r_idx[2:0];
        o_op.data   = i_rx_byte;
        case (r_phase)
            fsfp_pkg::PH_HDR1: begin
                if (i_rx_byte == r_header)
                    n_sum = i_rx_byte;
            end
            fsfp_pkg::PH_HDR2: begin
                if (i_rx_byte == r_header)
                    n_sum = r_sum + i_rx_byte;
            end
            fsfp_pkg::PH_FUNC: begin
                if (i_rx_byte < r_func_lim) begin
                    n_func = i_rx_byte;
                    n_sum  = r_sum + i_rx_byte;
                end
            end
            fsfp_pkg::PH_LEN: begin
                if (i_rx_byte < 8'(fsfp_pkg::MAX_LEN)) begin
                    n_rem = i_rx_byte[5:0];
                    n_idx = 6'd0;
                    n_sum = r_sum + i_rx_byte;
                end
            end
            fsfp_pkg::PH_PAY: begin
                if (r_rem != 6'd0) begin
                    n_rem       = r_rem - 6'd1;
                    n_idx       = r_idx + 6'd1;
                    n_sum       = r_sum + i_rx_byte;
                    o_op.wr_en  = w_idx_lo;
                    o_push      = i_accept && w_idx_lo;
                end
            end
            fsfp_pkg::PH_SUM: begin
                o_op.is_check = 1'b1;
                o_op.wr_en    = w_idx_lo;
                o_op.hit      = (i_rx_byte == r_sum) && (r_func == r_acc_func);
                o_push        = i_accept;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fsfp_pkg::PH_HDR1;
            r_rem   <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_func  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_func  <= n_func;
        end
    end

endmodule

/* rtl/core/fsfp_queue.sv */
// ----------------------------------------------------------------------------
// fsfp_queue
// Short FIFO of store/check operations between front and back.
// ----------------------------------------------------------------------------
module fsfp_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  fsfp_pkg::t_op                 i_op,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic                          o_avail,
    output fsfp_pkg::t_op                 o_op
);

    fsfp_pkg::t_op                 r_mem [fsfp_pkg::QDEPTH];
    logic [fsfp_pkg::QPTR_W-1:0]   r_wptr;
    logic [fsfp_pkg::QPTR_W-1:0]   r_rptr;
    logic [fsfp_pkg::QCNT_W-1:0]   r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_cnt == fsfp_pkg::QCNT_W'(fsfp_pkg::QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_op    = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wptr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push)
                r_wptr <= (r_wptr == fsfp_pkg::QPTR_W'(fsfp_pkg::QDEPTH - 1)) ? '0
                                                                            : r_wptr + 1'b1;
            if (w_pop)
                r_rptr <= (r_rptr == fsfp_pkg::QPTR_W'(fsfp_pkg::QDEPTH - 1)) ? '0
                                                                            : r_rptr + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/fsfp_back.sv */
// ----------------------------------------------------------------------------
// fsfp_back
// Payload store, frame counter and registered result stage.
// ----------------------------------------------------------------------------
module fsfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  fsfp_pkg::t_op       i_op,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_x_offset,
    output logic signed [15:0]  o_y_offset,
    output logic signed [15:0]  o_quality,
    output logic signed [15:0]  o_height,
    output logic [7:0]          o_frame_count
);

    logic [7:0]  r_store [8];
    logic [7:0]  n_store [8];
    logic [7:0]  r_count;
    logic        r_valid;
    logic [15:0] r_x, r_y, r_q, r_h;
    logic        w_emit;

    // Result stage free or draining this cycle.
    assign o_pop  = i_avail && (!r_valid || i_ready);
    assign w_emit = o_pop && i_op.is_check && i_op.hit;

    // Store contents after this operation's write.
    always_comb begin
        for (int k = 0; k < 8; k++)
            n_store[k] = r_store[k];
        if (i_op.wr_en)
            n_store[i_op.idx] = i_op.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++)
                r_store[k] <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                for (int k = 0; k < 8; k++)
                    r_store[k] <= n_store[k];
            end
            if (w_emit) begin
                r_count <= r_count + 8'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_x <= {n_store[0], n_store[1]};
            r_y <= {n_store[2], n_store[3]};
            r_q <= {n_store[4], n_store[5]};
            r_h <= {n_store[6], n_store[7]};
        end
    end

    assign o_valid       = r_valid;
    assign o_x_offset    = r_x;
    assign o_y_offset    = r_y;
    assign o_quality     = r_q;
    assign o_height      = r_h;
    assign o_frame_count = r_count;

endmodule

/* rtl/core/flow_sensor_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// flow_sensor_frame_parser_top
// Frame parser for a flow/height sensor serial link.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transaction (i_valid / o_ready,
// i_rx_byte). Frames are header, header, function, length, payload,
// checksum (mod-256 sum of all earlier frame bytes). A bad byte drops back
// to the header hunt.
// Output channel: one transaction per good frame whose function matches
// (o_valid / i_ready): four big-endian signed words from store bytes 0..7
// and the wrapping frame count.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data, write only, while idle.
// Throughput: one byte per cycle while o_ready is high. The front classifier
// pushes store/check ops into a 2-entry queue; the back applies them to the
// payload store. Result path: the checksum byte's op enters the queue, then
// the back pops it into the registered result stage, which raises o_valid.
// Stall: the back holds its result until taken and stops draining the queue
// meanwhile; once two ops are queued o_ready drops for every byte, including
// bytes that would not push an op.
// Reset (sync, active low): parser to header hunt, store and count zeroed,
// config to its defaults, queue and result stage emptied.
// ----------------------------------------------------------------------------
module flow_sensor_frame_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    // byte input
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    // frame result
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_x_offset,
    output logic signed [15:0]  o_y_offset,
    output logic signed [15:0]  o_quality,
    output logic signed [15:0]  o_height,
    output logic [7:0]          o_frame_count
);

    logic          w_accept;
    logic          w_push;
    fsfp_pkg::t_op w_push_op;
    logic          w_full;
    logic          w_pop;
    logic          w_avail;
    fsfp_pkg::t_op w_head_op;

    // Hold off input while the queue has no room for a possible push.
    assign o_ready  = !w_full;
    assign w_accept = i_valid && o_ready;

    fsfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    fsfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_op    (w_head_op)
    );

    fsfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (w_avail),
        .i_op          (w_head_op),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_x_offset    (o_x_offset),
        .o_y_offset    (o_y_offset),
        .o_quality     (o_quality),
        .o_height      (o_height),
        .o_frame_count (o_frame_count)
    );

endmodule

/* rtl/core/fsfp_checker.sv */
// ----------------------------------------------------------------------------
// fsfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module fsfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_x_offset,
    input logic signed [15:0] o_height,
    input logic [7:0]         o_frame_count
);

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_offset) && $stable(o_height)
                                && $stable(o_frame_count))
        else $error("result changed while stalled");

    // Successive results count up by one.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid || (o_frame_count == $past(o_frame_count) + 8'd1))
        else $error("frame count skipped");

    // Reset empties the result stage.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A shortest frame takes six bytes, so nothing can appear soon after reset.
    a_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n, 5) |-> !o_valid)
        else $error("result too soon after reset");

endmodule

bind flow_sensor_frame_parser_top fsfp_checker u_fsfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_x_offset    (o_x_offset),
    .o_height      (o_height),
    .o_frame_count (o_frame_count)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow sensor frame parser.
// ----------------------------------------------------------------------------
// Serial bytes go in over the valid/ready byte channel. A local model of the
// parser follows every accepted byte and queues the decoded sample that a
// good frame should produce. Each sample leaving the block is compared field
// by field with the oldest queued one.
// A short table of hand-built frames comes first: the field extremes, a short
// payload that picks up stale store bytes, a zero length and a rejected
// function. Random frames follow under several register settings, with
// random idle cycles on both channels and one long hold on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;       // 12 ns period
    localparam int RST_CYCLES   = 8;
    localparam int DRAIN_CYCLES = 8;       // covers the result stage plus the op queue
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;     // long result-side hold to fill the block

    // One decoded sample as it leaves the block.
    typedef struct packed {
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
        logic signed [15:0] quality;
        logic signed [15:0] height;
        logic [7:0]         frame_count;
    } t_flow_sample;

    // Directed table row: one byte, with a hand-written sample where it is obvious.
    typedef struct {
        logic [7:0]   rx;
        bit           typed;
        t_flow_sample want;
    } t_dir_row;

    typedef enum int {
        FR_GOOD,      // accepted function, correct checksum
        FR_OTHER_FN,  // random function code, not forced to differ from the accepted one
        FR_BAD_SUM,   // checksum off by a nonzero amount
        FR_CORRUPT,   // one byte anywhere in the frame replaced
        FR_BAD_LEN,   // zero length or length at/above MAX_LEN
        FR_NOISE      // a few random bytes
    } t_frame_kind;

    localparam t_flow_sample NO_SAMPLE = '0;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    logic [1:0]         i_cfg_idx  = '0;
    logic [7:0]         i_cfg_data = '0;
    logic               i_valid    = 1'b0;
    logic               o_ready;
    logic [7:0]         i_rx_byte  = '0;
    logic               o_valid;
    logic               i_ready    = 1'b0;
    logic signed [15:0] o_x_offset;
    logic signed [15:0] o_y_offset;
    logic signed [15:0] o_quality;
    logic signed [15:0] o_height;
    logic [7:0]         o_frame_count;

    always #CLK_HALF i_clk = ~i_clk;

    flow_sensor_frame_parser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_x_offset    (o_x_offset),
        .o_y_offset    (o_y_offset),
        .o_quality     (o_quality),
        .o_height      (o_height),
        .o_frame_count (o_frame_count)
    );

    // ------------------------------------------------------------------------
    // Parser model state: register copies and the frame walker, at reset values
    // ------------------------------------------------------------------------
    logic [7:0] hdr_cfg = fsfp_pkg::HEADER_RST;
    logic [7:0] lim_cfg = fsfp_pkg::FUNC_LIMIT_RST;
    logic [7:0] acc_cfg = fsfp_pkg::ACC_FUNC_RST;

    fsfp_pkg::t_phase pr_phase = fsfp_pkg::PH_HDR1;
    logic [5:0] pr_remaining = '0;
    logic [5:0] pr_index     = '0;
    logic [7:0] pr_sum       = '0;
    logic [7:0] pr_func      = '0;
    logic [7:0] pr_store [8] = '{default: 8'h00};
    logic [7:0] pr_count     = '0;

    t_flow_sample pending_samples[$];  // decoded samples not yet seen at the output
    t_flow_sample head_sample;

    int err_count       = 0;
    int bytes_sent      = 0;
    int samples_checked = 0;
    int settings_used   = 1;           // reset values count as the first setting
    int unsigned cycle_count = 0;

    bit src_idle    = 1'b1;            // sender inserts random gaps when set
    bit snk_idle    = 1'b1;            // receiver inserts random stalls when set
    int hold_cycles = 0;               // one-shot long stall request for the receiver

    // Walks one byte through the frame parser. Returns 1 with the decoded
    // sample when the byte closes a good frame of the accepted function.
    function automatic bit parse_rx_byte(input logic [7:0] b, output t_flow_sample s);
        bit hit;
        hit = 1'b0;
        s   = NO_SAMPLE;
        case (pr_phase)
            fsfp_pkg::PH_HDR1: begin
                if (b == hdr_cfg) begin
                    pr_sum   = b;
                    pr_phase = fsfp_pkg::PH_HDR2;
                end
            end
            fsfp_pkg::PH_HDR2: begin
                if (b == hdr_cfg) begin
                    pr_sum   = pr_sum + b;
                    pr_phase = fsfp_pkg::PH_FUNC;
                end else begin
                    pr_phase = fsfp_pkg::PH_HDR1;
                end
            end
            fsfp_pkg::PH_FUNC: begin
                if (b < lim_cfg) begin
                    pr_func  = b;
                    pr_sum   = pr_sum + b;
                    pr_phase = fsfp_pkg::PH_LEN;
                end else begin
                    pr_phase = fsfp_pkg::PH_HDR1;
                end
            end
            fsfp_pkg::PH_LEN: begin
                if (b < fsfp_pkg::MAX_LEN) begin
                    pr_remaining = b[5:0];
                    pr_index     = '0;
                    pr_sum       = pr_sum + b;
                    pr_phase     = fsfp_pkg::PH_PAY;
                end else begin
                    pr_phase = fsfp_pkg::PH_HDR1;
                end
            end
            fsfp_pkg::PH_PAY: begin
                // zero length lands here with nothing left: the byte drops the frame
                if (pr_remaining != 0) begin
                    pr_remaining = pr_remaining - 1'b1;
                    if (pr_index < 8)
                        pr_store[pr_index[2:0]] = b;
                    pr_index = pr_index + 1'b1;
                    pr_sum   = pr_sum + b;
                    if (pr_remaining == 0)
                        pr_phase = fsfp_pkg::PH_SUM;
                end else begin
                    pr_phase = fsfp_pkg::PH_HDR1;
                end
            end
            fsfp_pkg::PH_SUM: begin
                pr_phase = fsfp_pkg::PH_HDR1;
                // checksum byte also lands in the store after a short payload
                if (pr_index < 8)
                    pr_store[pr_index[2:0]] = b;
                if (b == pr_sum && pr_func == acc_cfg) begin
                    pr_count      = pr_count + 1'b1;
                    s.x_offset    = {pr_store[0], pr_store[1]};
                    s.y_offset    = {pr_store[2], pr_store[3]};
                    s.quality     = {pr_store[4], pr_store[5]};
                    s.height      = {pr_store[6], pr_store[7]};
                    s.frame_count = pr_count;
                    hit           = 1'b1;
                end
            end
            default: pr_phase = fsfp_pkg::PH_HDR1;
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and output checks
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("[%0t] ERROR sample %0d: %s", $time, samples_checked, msg);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Output monitor: every result transaction must match the oldest
    // queued sample. Samples are queued at byte acceptance, ahead of the
    // op queue and result register, so a sample never races its own check.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                flag_error("result transaction with no sample expected");
            end else begin
                head_sample = pending_samples.pop_front();
                cmp_field("x_offset", o_x_offset, head_sample.x_offset);
                cmp_field("y_offset", o_y_offset, head_sample.y_offset);
                cmp_field("quality", o_quality, head_sample.quality);
                cmp_field("height", o_height, head_sample.height);
                cmp_field("frame_count", {8'h00, o_frame_count},
                          {8'h00, head_sample.frame_count});
                samples_checked++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d samples still pending",
                     cycle_count, pending_samples.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls per transaction, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        forever begin
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = snk_idle ? $urandom_range(0, 7) : 0;
            end
            // ready only drops at the edge that took the last transaction
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && o_valid === 1'b1));
            if ($urandom_range(0, 11) == 0)
                snk_idle = !snk_idle;
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------
    // One byte transaction. Valid stays high across back-to-back bytes; the
    // model runs at the accepting edge and queues any sample it decodes.
    // Typed rows queue their hand-written sample instead.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_flow_sample want);
        int           gap;
        t_flow_sample s;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        bytes_sent++;
        if (parse_rx_byte(b, s) || typed)
            pending_samples.push_back(typed ? want : s);
    endtask

    // Stop offering bytes and let every queued sample and in-flight store op
    // drain, so that the registers can be rewritten safely.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges.
    task automatic load_settings(input logic [7:0] hdr, input logic [7:0] lim,
                                 input logic [7:0] acc);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= fsfp_pkg::CFG_HEADER;
        i_cfg_data <= hdr;
        @(posedge i_clk);
        i_cfg_idx  <= fsfp_pkg::CFG_FUNC_LIM;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_idx  <= fsfp_pkg::CFG_ACC_FUNC;
        i_cfg_data <= acc;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hdr_cfg = hdr;
        lim_cfg = lim;
        acc_cfg = acc;
        settings_used++;
    endtask

    // Builds one frame of the given kind from the current settings and sends it.
    task automatic send_frame(input t_frame_kind kind);
        logic [7:0] fr[$];
        logic [7:0] fn;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         n_pay;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 6)) fr.push_back(8'($urandom));
        end else begin
            fn = acc_cfg;
            if (kind == FR_OTHER_FN)
                fn = (lim_cfg != 0 && $urandom_range(0, 1) == 1) ?
                     8'($urandom_range(0, lim_cfg - 1)) : 8'($urandom);
            // mostly short payloads; long ones run past the 8-byte store
            if (kind == FR_BAD_LEN)
                len = ($urandom_range(0, 2) == 0) ? 8'd0 :
                      8'($urandom_range(fsfp_pkg::MAX_LEN, 255));
            else if ($urandom_range(0, 9) == 0)
                len = 8'($urandom_range(9, fsfp_pkg::MAX_LEN - 1));
            else
                len = 8'($urandom_range(1, 8));
            n_pay = (len < fsfp_pkg::MAX_LEN) ? int'(len) : $urandom_range(0, 4);
            fr  = '{hdr_cfg, hdr_cfg, fn, len};
            sum = hdr_cfg + hdr_cfg + fn + len;
            repeat (n_pay) begin
                b = 8'($urandom);
                fr.push_back(b);
                sum = sum + b;
            end
            if (kind == FR_BAD_SUM)
                sum = sum + 8'($urandom_range(1, 255));
            fr.push_back(sum);
            if (kind == FR_CORRUPT)
                fr[$urandom_range(0, fr.size() - 1)] = 8'($urandom);
        end
        foreach (fr[k])
            send_byte(fr[k], 1'b0, NO_SAMPLE);
    endtask

    // One setting: drain, write the registers, then random frames until
    // about n_bytes more bytes have gone in. Mostly good frames.
    task automatic run_phase(input logic [7:0] hdr, input logic [7:0] lim,
                             input logic [7:0] acc, input int n_bytes);
        int          stop_at;
        int          pick;
        t_frame_kind kind;
        wait_idle();
        load_settings(hdr, lim, acc);
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 55) ? FR_GOOD :
                   (pick < 68) ? FR_OTHER_FN :
                   (pick < 76) ? FR_BAD_SUM :
                   (pick < 85) ? FR_CORRUPT :
                   (pick < 92) ? FR_BAD_LEN : FR_NOISE;
            if ($urandom_range(0, 15) == 0)
                src_idle = !src_idle;
            send_frame(kind);
        end
    endtask

    // Hand-built frames under reset settings (header AA, limit F2, accept F1).
    t_dir_row dir_tab [27] = '{
        // full frame, payload at the signed extremes: 8000 7FFF 0001 FFFF
        '{8'hAA, 1'b0, NO_SAMPLE}, '{8'hAA, 1'b0, NO_SAMPLE},
        '{8'hF1, 1'b0, NO_SAMPLE}, '{8'h08, 1'b0, NO_SAMPLE},
        '{8'h80, 1'b0, NO_SAMPLE}, '{8'h00, 1'b0, NO_SAMPLE},
        '{8'h7F, 1'b0, NO_SAMPLE}, '{8'hFF, 1'b0, NO_SAMPLE},
        '{8'h00, 1'b0, NO_SAMPLE}, '{8'h01, 1'b0, NO_SAMPLE},
        '{8'hFF, 1'b0, NO_SAMPLE}, '{8'hFF, 1'b0, NO_SAMPLE},
        '{8'h4A, 1'b1, '{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 8'd1}},
        // one-byte payload: checksum lands at store slot 1, slots 2..7 are stale
        '{8'hAA, 1'b0, NO_SAMPLE}, '{8'hAA, 1'b0, NO_SAMPLE},
        '{8'hF1, 1'b0, NO_SAMPLE}, '{8'h01, 1'b0, NO_SAMPLE},
        '{8'h12, 1'b0, NO_SAMPLE},
        '{8'h58, 1'b1, '{16'h1258, 16'h7FFF, 16'h0001, 16'hFFFF, 8'd2}},
        // zero length: the next byte drops the frame and is not taken as a header
        '{8'hAA, 1'b0, NO_SAMPLE}, '{8'hAA, 1'b0, NO_SAMPLE},
        '{8'hF1, 1'b0, NO_SAMPLE}, '{8'h00, 1'b0, NO_SAMPLE},
        '{8'hAA, 1'b0, NO_SAMPLE},
        // function equal to the limit is rejected
        '{8'hAA, 1'b0, NO_SAMPLE}, '{8'hAA, 1'b0, NO_SAMPLE},
        '{8'hF2, 1'b0, NO_SAMPLE}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] rnd_hdr;
        logic [7:0] rnd_lim;
        logic [7:0] rnd_acc;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reset settings
        foreach (dir_tab[r])
            send_byte(dir_tab[r].rx, dir_tab[r].typed, dir_tab[r].want);

        // Back-pressure: the receiver takes one sample and then holds off for a
        // long stretch while good frames keep coming back to back, so the held
        // result plus the op queue fill up and o_ready has to drop.
        wait_idle();
        src_idle    = 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (5) send_frame(FR_GOOD);
        src_idle = 1'b1;

        // random frames over a spread of settings, extremes included
        run_phase(fsfp_pkg::HEADER_RST, fsfp_pkg::FUNC_LIMIT_RST, fsfp_pkg::ACC_FUNC_RST,
                  400);
        run_phase(8'h00, 8'hFF, 8'hFE, 300);
        run_phase(8'hFF, 8'h00, 8'h00, 100);    // nothing is below a zero limit
        repeat (2) begin
            rnd_hdr = 8'($urandom);
            rnd_lim = 8'($urandom_range(2, 255));
            rnd_acc = 8'($urandom_range(0, rnd_lim - 1));
            run_phase(rnd_hdr, rnd_lim, rnd_acc, 250);
        end
        run_phase(8'h5A, 8'h10, 8'h30, 100);    // accepted code above the limit
        run_phase(8'hA5, 8'h81, 8'h80, 150);    // accepted code one below the limit

        // let the tail drain, then watch a little longer for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes under %0d register settings", bytes_sent,
                 settings_used);
        $display("%0d decoded samples compared, %0d mismatches", samples_checked,
                 err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* flow_sensor_frame_parser_top.f */
rtl/core/fsfp_pkg.sv
rtl/core/fsfp_front.sv
rtl/core/fsfp_queue.sv
rtl/core/fsfp_back.sv
rtl/core/flow_sensor_frame_parser_top.sv
rtl/core/fsfp_checker.sv
verif/tb_top.sv
